// ===== src/three_stacks_in_one_memory_top_macros.svh =====
// Assertion macros for the three-stack top level
`ifndef THREE_STACKS_IN_ONE_MEMORY_TOP_MACROS_SVH
`define THREE_STACKS_IN_ONE_MEMORY_TOP_MACROS_SVH

// implication on i_clk, checked every edge outside reset
`define TSOM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define TSOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tsom_pkg.sv =====
// Package: types, constants and helpers for the three-stack memory block
`timescale 1ns / 1ps

package tsom_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_STACKS  = 3;
    localparam int MEM_DEPTH   = NUM_STACKS * STACK_DEPTH;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int DATA_W      = 32;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SEL_DOWN = 2'd0,
        SEL_MID  = 2'd1,
        SEL_UP   = 2'd2
    } t_sel;

    typedef struct packed {
        t_command                  command;
        logic [1:0]                stack_select;
        logic signed [DATA_W-1:0]  push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  pop_value;
        t_status                   status;
        logic [NUM_STACKS-1:0]     empty_flags;
        logic [NUM_STACKS-1:0]     full_flags;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] sel,
                                                    input logic [FILL_W-1:0] pos);
        logic [ADDR_W-1:0] pos_ext;
        logic [ADDR_W-1:0] addr;
        pos_ext = ADDR_W'(pos);
        case (sel)
            SEL_DOWN: addr = ADDR_W'(STACK_DEPTH - 1) - pos_ext;
            SEL_MID:  addr = ADDR_W'(STACK_DEPTH) + pos_ext;
            SEL_UP:   addr = ADDR_W'(2 * STACK_DEPTH) + pos_ext;
            default:  addr = '0;
        endcase
        return addr;
    endfunction

endpackage

// ===== src/three_stacks_in_one_memory_top.sv =====
// Top level: three LIFO stacks sharing one 3*STACK_DEPTH-word memory.
// An accepted input passes through the execute step and then the load step into the result register.
// A new transaction is accepted only after the previous one has been loaded as a result.
// A waiting result holds the controller in its load step, which stalls further inputs.
// Reset (synchronous, active low) empties all stacks; memory contents are kept.
`timescale 1ns / 1ps

`include "three_stacks_in_one_memory_top_macros.svh"

module three_stacks_in_one_memory_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tsom_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tsom_pkg::t_out_item o_out_data
);

    tsom_pkg::t_ctl_cmd ctl_cmd;
    tsom_pkg::t_dp_sts  dp_sts;
    logic               in_fire;
    logic               out_refused;
    logic               flag_clash;

    tsom_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (ctl_cmd)
    );

    tsom_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (ctl_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_refused = o_out_valid && (o_out_data.status != tsom_pkg::ST_DONE);
    assign flag_clash  = |(o_out_data.empty_flags & o_out_data.full_flags);

    `TSOM_ASSERT_IMPL(a_refused_zero, out_refused, o_out_data.pop_value == '0, "refused data")
    `TSOM_ASSERT_IMPL(a_flags_excl, o_out_valid, !flag_clash, "stack both empty and full")
    `TSOM_ASSERT_NEXT(a_one_at_time, in_fire, !o_in_ready, "input accepted while busy")

endmodule

// ===== src/tsom_ctrl.sv =====
// Controller state machine: sequences accept, execute and result load
`timescale 1ns / 1ps

module tsom_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tsom_pkg::t_dp_sts  i_sts,
    output tsom_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/tsom_datapath.sv =====
// Datapath: shared stack memory, fill counters and result register
`timescale 1ns / 1ps

module tsom_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsom_pkg::t_in_item  i_in_data,
    input  tsom_pkg::t_ctl_cmd  i_cmd,
    output tsom_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tsom_pkg::t_out_item o_out_data
);

    logic [tsom_pkg::DATA_W-1:0] r_mem [tsom_pkg::MEM_DEPTH];

    tsom_pkg::t_in_item          r_in;
    logic [tsom_pkg::FILL_W-1:0] r_fill [tsom_pkg::NUM_STACKS];
    logic [tsom_pkg::FILL_W-1:0] n_fill_sel;
    logic [tsom_pkg::DATA_W-1:0] r_rd_data;
    tsom_pkg::t_status           r_status;
    tsom_pkg::t_status           n_status;
    logic                        r_pop_ok;
    logic                        r_out_valid;
    tsom_pkg::t_out_item         r_out;

    logic [tsom_pkg::FILL_W-1:0] fill_cur;
    logic                        sel_ok;
    logic                        is_full;
    logic                        is_empty;
    logic                        do_push;
    logic                        do_pop;
    logic [tsom_pkg::ADDR_W-1:0] mem_addr;
    logic [tsom_pkg::NUM_STACKS-1:0] empty_vec;
    logic [tsom_pkg::NUM_STACKS-1:0] full_vec;

    always_comb begin
        sel_ok   = 1'b1;
        fill_cur = '0;
        case (r_in.stack_select)
            tsom_pkg::SEL_DOWN: fill_cur = r_fill[0];
            tsom_pkg::SEL_MID:  fill_cur = r_fill[1];
            tsom_pkg::SEL_UP:   fill_cur = r_fill[2];
            default:            sel_ok   = 1'b0;
        endcase
    end

    assign is_full  = !sel_ok || (fill_cur >= tsom_pkg::FILL_W'(tsom_pkg::STACK_DEPTH));
    assign is_empty = !sel_ok || (fill_cur == '0);
    assign do_push  = i_cmd.exec && (r_in.command == tsom_pkg::CMD_PUSH) && !is_full;
    assign do_pop   = i_cmd.exec && (r_in.command == tsom_pkg::CMD_POP) && !is_empty;

    always_comb begin
        n_fill_sel = fill_cur;
        mem_addr   = tsom_pkg::slot_addr(r_in.stack_select, fill_cur);
        if (r_in.command == tsom_pkg::CMD_POP) begin
            n_fill_sel = fill_cur - tsom_pkg::FILL_W'(1);
            mem_addr   = tsom_pkg::slot_addr(r_in.stack_select, n_fill_sel);
        end else begin
            n_fill_sel = fill_cur + tsom_pkg::FILL_W'(1);
        end
    end

    always_comb begin
        n_status = tsom_pkg::ST_DONE;
        if (r_in.command == tsom_pkg::CMD_PUSH) begin
            if (is_full) begin
                n_status = tsom_pkg::ST_FULL;
            end
        end else if (is_empty) begin
            n_status = tsom_pkg::ST_EMPTY;
        end
    end

    always_comb begin
        for (int k = 0; k < tsom_pkg::NUM_STACKS; k++) begin
            empty_vec[k] = (r_fill[k] == '0);
            full_vec[k]  = (r_fill[k] >= tsom_pkg::FILL_W'(tsom_pkg::STACK_DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[mem_addr] <= r_in.push_value;
        end
        if (do_pop) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= do_pop;
        end
        if (i_cmd.load_out) begin
            r_out.pop_value   <= r_pop_ok ? r_rd_data : '0;
            r_out.status      <= r_status;
            r_out.empty_flags <= empty_vec;
            r_out.full_flags  <= full_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tsom_pkg::NUM_STACKS; k++) begin
                r_fill[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (do_push || do_pop) begin
                r_fill[r_in.stack_select] <= n_fill_sel;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ===== dv/testbench.sv =====
// Testbench: directed and random push/pop traffic checked against a shadow of the stacks
`timescale 1ns / 1ps

module testbench;

    localparam tsom_pkg::t_command C_PUSH  = tsom_pkg::CMD_PUSH;
    localparam tsom_pkg::t_command C_POP   = tsom_pkg::CMD_POP;
    localparam tsom_pkg::t_status  R_DONE  = tsom_pkg::ST_DONE;
    localparam tsom_pkg::t_status  R_FULL  = tsom_pkg::ST_FULL;
    localparam tsom_pkg::t_status  R_EMPTY = tsom_pkg::ST_EMPTY;
    localparam logic [1:0] S_DOWN   = tsom_pkg::SEL_DOWN;
    localparam logic [1:0] S_MID    = tsom_pkg::SEL_MID;
    localparam logic [1:0] S_UP     = tsom_pkg::SEL_UP;
    localparam logic [1:0] SEL_NONE = 2'd3;
    localparam int RAND_ITEMS = 760;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        tsom_pkg::t_in_item  item;
        int                  reps;
        bit                  rnd_val;
        bit                  known;
        tsom_pkg::t_out_item want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    tsom_pkg::t_in_item  in_data = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    tsom_pkg::t_out_item out_data;

    logic [tsom_pkg::DATA_W-1:0] shadow_mem [tsom_pkg::MEM_DEPTH];
    int unsigned                 shadow_fill [tsom_pkg::NUM_STACKS];
    tsom_pkg::t_out_item         expected_results [$];
    t_dir_row                    dir_rows [$];
    int                          errors = 0;
    int                          quiet_cycles = 0;

    three_stacks_in_one_memory_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned slot_of(input int unsigned s, input int unsigned pos);
        if (s == 0)
            return tsom_pkg::STACK_DEPTH - 1 - pos;
        return s * tsom_pkg::STACK_DEPTH + pos;
    endfunction

    function automatic tsom_pkg::t_out_item stack_op_result(input tsom_pkg::t_in_item it);
        tsom_pkg::t_out_item r;
        int unsigned         s;
        s = it.stack_select;
        r = '0;
        r.status = R_DONE;
        if (it.command == C_PUSH) begin
            if (s >= tsom_pkg::NUM_STACKS || shadow_fill[s] >= tsom_pkg::STACK_DEPTH) begin
                r.status = R_FULL;
            end else begin
                shadow_mem[slot_of(s, shadow_fill[s])] = it.push_value;
                shadow_fill[s]++;
            end
        end else begin
            if (s >= tsom_pkg::NUM_STACKS || shadow_fill[s] == 0) begin
                r.status = R_EMPTY;
            end else begin
                shadow_fill[s]--;
                r.pop_value = shadow_mem[slot_of(s, shadow_fill[s])];
            end
        end
        for (int k = 0; k < tsom_pkg::NUM_STACKS; k++) begin
            r.empty_flags[k] = (shadow_fill[k] == 0);
            r.full_flags[k]  = (shadow_fill[k] >= tsom_pkg::STACK_DEPTH);
        end
        return r;
    endfunction

    task automatic dir_row(input tsom_pkg::t_command c, input logic [1:0] s,
                           input logic [31:0] v, input int reps, input bit rnd);
        t_dir_row row;
        row.item = '{command: c, stack_select: s, push_value: v};
        row.reps = reps;
        row.rnd_val = rnd;
        row.known = 1'b0;
        row.want = '0;
        dir_rows.push_back(row);
    endtask

    task automatic dir_known(input tsom_pkg::t_command c, input logic [1:0] s,
                             input logic [31:0] v, input logic [31:0] pv,
                             input tsom_pkg::t_status st,
                             input logic [2:0] e, input logic [2:0] f);
        t_dir_row row;
        row.item = '{command: c, stack_select: s, push_value: v};
        row.reps = 1;
        row.rnd_val = 1'b0;
        row.known = 1'b1;
        row.want = '{pop_value: pv, status: st, empty_flags: e, full_flags: f};
        dir_rows.push_back(row);
    endtask

    task automatic send_item(input tsom_pkg::t_in_item it, input bit known,
                             input tsom_pkg::t_out_item want, input bit may_idle);
        tsom_pkg::t_out_item predicted;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        predicted = stack_op_result(it);
        expected_results.push_back(known ? want : predicted);
        if (may_idle && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 30);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        tsom_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction expected none actual %h",
                         $time, out_data);
            end else begin
                want = expected_results.pop_front();
                check_field("pop_value", want.pop_value, out_data.pop_value);
                check_field("status", 32'(want.status), 32'(out_data.status));
                check_field("empty_flags", 32'(want.empty_flags), 32'(out_data.empty_flags));
                check_field("full_flags", 32'(want.full_flags), 32'(out_data.full_flags));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL three_stacks_in_one_memory_top");
            $finish;
        end
    end

    initial begin
        int cyc;
        cyc = 0;
        wait (rst_n);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= 1500 && cyc < 1700)
                out_ready <= 1'b0;
            else if (cyc >= 600 && cyc < 1000)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 30);
        end
    end

    initial begin
        tsom_pkg::t_in_item  it;
        tsom_pkg::t_out_item none;
        int                  fav;
        int                  push_pct;
        int                  burst;
        int                  pick;

        for (int k = 0; k < tsom_pkg::NUM_STACKS; k++)
            shadow_fill[k] = 0;
        none = '0;

        dir_known(C_POP,  S_DOWN,   32'd0, 32'd0, R_EMPTY, 3'b111, 3'b000);
        dir_known(C_POP,  S_MID,    32'd0, 32'd0, R_EMPTY, 3'b111, 3'b000);
        dir_known(C_POP,  S_UP,     32'd0, 32'd0, R_EMPTY, 3'b111, 3'b000);
        dir_known(C_POP,  SEL_NONE, 32'd0, 32'd0, R_EMPTY, 3'b111, 3'b000);
        dir_known(C_PUSH, SEL_NONE, 32'd5, 32'd0, R_FULL,  3'b111, 3'b000);
        dir_known(C_PUSH, S_DOWN,   32'h7fffffff, 32'd0, R_DONE, 3'b110, 3'b000);
        dir_known(C_PUSH, S_MID,    32'h80000000, 32'd0, R_DONE, 3'b100, 3'b000);
        dir_known(C_PUSH, S_UP,     32'hffffffff, 32'd0, R_DONE, 3'b000, 3'b000);
        dir_row(C_PUSH, S_DOWN, 32'd0, tsom_pkg::STACK_DEPTH - 1, 1'b1);
        dir_known(C_PUSH, S_DOWN,   32'h12345678, 32'd0, R_FULL, 3'b000, 3'b001);
        dir_known(C_POP,  SEL_NONE, 32'hffffffff, 32'd0, R_EMPTY, 3'b000, 3'b001);
        dir_known(C_POP,  S_MID,    32'd0, 32'h80000000, R_DONE, 3'b010, 3'b001);
        dir_known(C_POP,  S_UP,     32'd0, 32'hffffffff, R_DONE, 3'b110, 3'b001);
        dir_row(C_POP, S_DOWN, 32'd0, tsom_pkg::STACK_DEPTH - 1, 1'b0);
        dir_known(C_POP,  S_DOWN,   32'd0, 32'h7fffffff, R_DONE, 3'b111, 3'b000);
        dir_known(C_POP,  S_DOWN,   32'd0, 32'd0, R_EMPTY, 3'b111, 3'b000);

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            for (int r = 0; r < dir_rows[i].reps; r++) begin
                it = dir_rows[i].item;
                if (dir_rows[i].rnd_val)
                    it.push_value = $urandom;
                send_item(it, dir_rows[i].known, dir_rows[i].want, 1'b1);
            end
        end

        burst = 0;
        fav = 0;
        push_pct = 50;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(10, 60);
                fav = $urandom_range(0, 2);
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            burst--;
            if (n == 400) begin
                in_valid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            it.command = ($urandom_range(99) < push_pct) ? C_PUSH : C_POP;
            pick = $urandom_range(99);
            if (pick < 5)
                it.stack_select = SEL_NONE;
            else if (pick < 30)
                it.stack_select = 2'($urandom_range(0, 2));
            else
                it.stack_select = 2'(fav);
            case ($urandom_range(0, 9))
                0:       it.push_value = 32'h7fffffff;
                1:       it.push_value = 32'h80000000;
                2:       it.push_value = 32'hffffffff;
                3:       it.push_value = 32'd0;
                default: it.push_value = $urandom;
            endcase
            send_item(it, 1'b0, none, !(n >= 100 && n < 300));
        end

        in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS three_stacks_in_one_memory_top");
        else
            $display("FAIL three_stacks_in_one_memory_top");
        $finish;
    end

endmodule
